### hdl/ccx_pkg.sv
package ccx_pkg;

  localparam int unsigned DOUBLE_ROUNDS = 10;
  localparam int unsigned NUM_ROUNDS    = 2 * DOUBLE_ROUNDS;
  localparam int unsigned ROUND_W       = $clog2(NUM_ROUNDS);
  localparam int unsigned NUM_WORDS     = 16;
  localparam int unsigned IDX_W         = $clog2(NUM_WORDS);
  localparam int unsigned NUM_BANKS     = 2;
  localparam int unsigned KS_DEPTH      = NUM_BANKS * NUM_WORDS;
  localparam int unsigned ADDR_W        = $clog2(KS_DEPTH);
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 64;

  typedef logic [31:0] word_t;
  typedef logic [NUM_WORDS-1:0][31:0] blk_t;

  localparam logic [3:0][31:0] SIGMA = {
    32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
  };

  localparam logic [CFG_IDX_W-1:0] REG_KEY0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE0  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE1  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_CT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_KS_ONLY = 3'd7;

  typedef struct packed {
    logic start;
    logic abort;
  } gen_ctrl_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic             wr_en;
    logic [IDX_W-1:0] idx;
    word_t            data;
  } gen_out_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    word_t             data;
  } ks_wr_t;

endpackage

### hdl/ccx_core.sv
module ccx_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ccx_pkg::gen_ctrl_t ctrl_i,
  input  ccx_pkg::blk_t     init_i,
  output ccx_pkg::gen_out_t gen_o
);

  localparam logic [1:0] G_IDLE  = 2'd0;
  localparam logic [1:0] G_ROUND = 2'd1;
  localparam logic [1:0] G_WRITE = 2'd2;

  logic [1:0]                  state_q, state_d;
  logic [ccx_pkg::ROUND_W-1:0] rnd_q, rnd_d;
  logic [ccx_pkg::IDX_W-1:0]   widx_q, widx_d;
  ccx_pkg::blk_t               work_q, work_d, rnd_res;

  function automatic ccx_pkg::word_t rotl(input ccx_pkg::word_t v, input int unsigned r);
    return (v << r) | (v >> (32 - r));
  endfunction

  function automatic logic [3:0][31:0] qr(input ccx_pkg::word_t a, input ccx_pkg::word_t b,
                                          input ccx_pkg::word_t c, input ccx_pkg::word_t d);
    ccx_pkg::word_t a1, b1, c1, d1;
    a1 = a + b;   d1 = rotl(d ^ a1, 16);
    c1 = c + d1;  b1 = rotl(b ^ c1, 12);
    a1 = a1 + b1; d1 = rotl(d1 ^ a1, 8);
    c1 = c1 + d1; b1 = rotl(b1 ^ c1, 7);
    return {d1, c1, b1, a1};
  endfunction

  // one column or diagonal round
  always_comb begin
    logic [3:0][31:0] r;
    rnd_res = work_q;
    for (int i = 0; i < 4; i++) begin
      if (!rnd_q[0]) begin
        r = qr(work_q[i], work_q[4 + i], work_q[8 + i], work_q[12 + i]);
        rnd_res[i]      = r[0];
        rnd_res[4 + i]  = r[1];
        rnd_res[8 + i]  = r[2];
        rnd_res[12 + i] = r[3];
      end else begin
        r = qr(work_q[i], work_q[4 + ((i + 1) & 3)], work_q[8 + ((i + 2) & 3)],
               work_q[12 + ((i + 3) & 3)]);
        rnd_res[i]                    = r[0];
        rnd_res[4 + ((i + 1) & 3)]  = r[1];
        rnd_res[8 + ((i + 2) & 3)]  = r[2];
        rnd_res[12 + ((i + 3) & 3)] = r[3];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    widx_d  = widx_q;
    work_d  = work_q;
    gen_o   = '0;
    gen_o.idx  = widx_q;
    gen_o.data = work_q[widx_q] + init_i[widx_q];
    unique case (state_q)
      G_IDLE: begin
        if (ctrl_i.start) begin
          work_d  = init_i;
          rnd_d   = '0;
          state_d = G_ROUND;
        end
      end
      G_ROUND: begin
        gen_o.busy = 1'b1;
        work_d     = rnd_res;
        rnd_d      = rnd_q + ccx_pkg::ROUND_W'(1);
        if (rnd_q == ccx_pkg::ROUND_W'(ccx_pkg::NUM_ROUNDS - 1)) begin
          widx_d  = '0;
          state_d = G_WRITE;
        end
      end
      G_WRITE: begin
        gen_o.busy  = 1'b1;
        gen_o.wr_en = 1'b1;
        widx_d      = widx_q + ccx_pkg::IDX_W'(1);
        if (widx_q == ccx_pkg::IDX_W'(ccx_pkg::NUM_WORDS - 1)) begin
          gen_o.done = 1'b1;
          state_d    = G_IDLE;
        end
      end
      default: state_d = G_IDLE;
    endcase
    // abort drops the block under way
    if (ctrl_i.abort) begin
      state_d     = G_IDLE;
      gen_o.wr_en = 1'b0;
      gen_o.done  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= G_IDLE;
      rnd_q   <= '0;
      widx_q  <= '0;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      widx_q  <= widx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

endmodule

### hdl/ccx_ksbuf.sv
module ccx_ksbuf (
  input  logic                       clk_i,
  input  ccx_pkg::ks_wr_t            wr_i,
  input  logic                       rd_en_i,
  input  logic [ccx_pkg::ADDR_W-1:0] rd_addr_i,
  output ccx_pkg::word_t             rd_data_o
);

  ccx_pkg::word_t mem [ccx_pkg::KS_DEPTH];
  ccx_pkg::word_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### hdl/chacha20_stream_xor.sv
// channel  | handshake                  | payload
// ---------+----------------------------+-------------------------------------------
// input    | in_valid_i / in_ready_o    | data_in_i, byte_count_i, last_word_i
// output   | out_valid_o / out_ready_i  | data_out_o, out_byte_count_o, out_last_o
// config   | cfg_we_i (no wait)         | cfg_idx_i, cfg_wdata_i
//
// a block takes a start step, the round steps and the write steps into a two-bank
// keystream ram, while the next block is built beside the one being read; words inside a
// ready bank go at one per cycle while the output does not stall, and an accepted word
// passes the read stage and then the output register.
// after reset, a last word or a config write between blocks, the next word waits for a new block.
// output register plus read stage let input take one more word while output stalls.
module chacha20_stream_xor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ccx_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ccx_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [31:0]                   data_in_i,
  input  logic [2:0]                    byte_count_i,
  input  logic                          last_word_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [31:0]                   data_out_o,
  output logic [2:0]                    out_byte_count_o,
  output logic                          out_last_o
);

  // config registers
  logic [3:0][63:0] key_q;
  logic [63:0]      nonce0_q;
  logic [31:0]      nonce1_q;
  logic [31:0]      init_ctr_q;
  logic             ks_only_q;

  // control
  logic [ccx_pkg::IDX_W-1:0]     pos_q, pos_d;
  logic                          rd_bank_q, rd_bank_d;
  logic [ccx_pkg::NUM_BANKS-1:0] full_q, full_d;
  logic                          gen_bank_q, gen_bank_d;
  logic [31:0]                   gen_ctr_q, gen_ctr_d;
  logic [31:0]                   rd_ctr_q, rd_ctr_d;
  logic                          msg_start_q, msg_start_d;
  logic                          restart_q;

  // read stage and output register
  logic        s1_valid_q;
  logic [31:0] s1_data_q;
  logic [2:0]  s1_cnt_q;
  logic        s1_last_q;
  logic        out_valid_q;
  logic [31:0] out_data_q;
  logic [2:0]  out_cnt_q;
  logic        out_last_q;

  logic               accept, s1_adv, trig, end_msg;
  logic [2:0]         cnt_sat;
  logic [31:0]        mask, ks_word, res_word;
  logic [31:0]        base_ctr;
  ccx_pkg::blk_t      init_blk;
  ccx_pkg::gen_ctrl_t gen_ctrl;
  ccx_pkg::gen_out_t  gen_out;
  ccx_pkg::ks_wr_t    ks_wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q      <= '0;
      nonce0_q   <= '0;
      nonce1_q   <= '0;
      init_ctr_q <= '0;
      ks_only_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ccx_pkg::REG_KEY0:    key_q[0]   <= cfg_wdata_i;
        ccx_pkg::REG_KEY1:    key_q[1]   <= cfg_wdata_i;
        ccx_pkg::REG_KEY2:    key_q[2]   <= cfg_wdata_i;
        ccx_pkg::REG_KEY3:    key_q[3]   <= cfg_wdata_i;
        ccx_pkg::REG_NONCE0:  nonce0_q   <= cfg_wdata_i;
        ccx_pkg::REG_NONCE1:  nonce1_q   <= cfg_wdata_i[31:0];
        ccx_pkg::REG_INIT_CT: init_ctr_q <= cfg_wdata_i[31:0];
        ccx_pkg::REG_KS_ONLY: ks_only_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    init_blk[3:0] = ccx_pkg::SIGMA;
    for (int i = 0; i < 4; i++) begin
      init_blk[4 + 2 * i] = key_q[i][31:0];
      init_blk[5 + 2 * i] = key_q[i][63:32];
    end
    init_blk[12] = gen_ctr_q;
    init_blk[13] = nonce0_q[31:0];
    init_blk[14] = nonce0_q[63:32];
    init_blk[15] = nonce1_q;
  end

  assign s1_adv     = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~restart_q & full_q[rd_bank_q] & (~s1_valid_q | s1_adv);
  assign accept     = in_valid_i & in_ready_o;
  assign end_msg    = accept & last_word_i;
  assign trig       = cfg_we_i | end_msg;

  assign gen_ctrl.start = ~restart_q & ~gen_out.busy & ~full_q[gen_bank_q];
  assign gen_ctrl.abort = trig;

  ccx_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (gen_ctrl),
    .init_i (init_blk),
    .gen_o  (gen_out)
  );

  assign ks_wr.en   = gen_out.wr_en;
  assign ks_wr.addr = {gen_bank_q, gen_out.idx};
  assign ks_wr.data = gen_out.data;

  ccx_ksbuf u_ksbuf (
    .clk_i     (clk_i),
    .wr_i      (ks_wr),
    .rd_en_i   (accept),
    .rd_addr_i ({rd_bank_q, pos_q}),
    .rd_data_o (ks_word)
  );

  assign base_ctr = msg_start_q ? init_ctr_q : rd_ctr_q;

  always_comb begin
    pos_d       = pos_q;
    rd_bank_d   = rd_bank_q;
    full_d      = full_q;
    gen_bank_d  = gen_bank_q;
    gen_ctr_d   = gen_ctr_q;
    rd_ctr_d    = rd_ctr_q;
    msg_start_d = msg_start_q;
    if (accept) begin
      msg_start_d = 1'b0;
      pos_d       = pos_q + ccx_pkg::IDX_W'(1);
      if (last_word_i) begin
        pos_d       = '0;
        msg_start_d = 1'b1;
      end else if (pos_q == ccx_pkg::IDX_W'(ccx_pkg::NUM_WORDS - 1)) begin
        full_d[rd_bank_q] = 1'b0;
        rd_bank_d         = ~rd_bank_q;
        rd_ctr_d          = rd_ctr_q + 32'd1;
      end
    end
    if (gen_out.done) begin
      full_d[gen_bank_q] = 1'b1;
      gen_bank_d         = ~gen_bank_q;
      gen_ctr_d          = gen_ctr_q + 32'd1;
    end
    // drop prefetched banks; a bank part way through a message is kept
    if (trig) begin
      full_d[~rd_bank_q] = 1'b0;
      if (end_msg || pos_q == '0) begin
        full_d[rd_bank_q] = 1'b0;
      end
    end
    if (restart_q) begin
      if (pos_q != '0) begin
        gen_bank_d = ~rd_bank_q;
        gen_ctr_d  = rd_ctr_q + 32'd1;
      end else begin
        gen_bank_d = rd_bank_q;
        gen_ctr_d  = base_ctr;
        rd_ctr_d   = base_ctr;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      rd_bank_q   <= 1'b0;
      full_q      <= '0;
      gen_bank_q  <= 1'b0;
      gen_ctr_q   <= '0;
      rd_ctr_q    <= '0;
      msg_start_q <= 1'b1;
      restart_q   <= 1'b1;
    end else begin
      pos_q       <= pos_d;
      rd_bank_q   <= rd_bank_d;
      full_q      <= full_d;
      gen_bank_q  <= gen_bank_d;
      gen_ctr_q   <= gen_ctr_d;
      rd_ctr_q    <= rd_ctr_d;
      msg_start_q <= msg_start_d;
      restart_q   <= trig;
    end
  end

  // byte count clamped to 1..4
  always_comb begin
    if (byte_count_i == 3'd0) begin
      cnt_sat = 3'd1;
    end else if (byte_count_i[2]) begin
      cnt_sat = 3'd4;
    end else begin
      cnt_sat = byte_count_i;
    end
  end

  always_comb begin
    unique case (s1_cnt_q)
      3'd1:    mask = 32'h0000_00ff;
      3'd2:    mask = 32'h0000_ffff;
      3'd3:    mask = 32'h00ff_ffff;
      default: mask = 32'hffff_ffff;
    endcase
  end

  assign res_word = (ks_only_q ? ks_word : (s1_data_q ^ ks_word)) & mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_data_q <= data_in_i;
      s1_cnt_q  <= cnt_sat;
      s1_last_q <= last_word_i;
    end
    if (s1_adv) begin
      out_data_q <= res_word;
      out_cnt_q  <= s1_cnt_q;
      out_last_q <= s1_last_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign data_out_o       = out_data_q;
  assign out_byte_count_o = out_cnt_q;
  assign out_last_o       = out_last_q;

endmodule
